[rtl/core/pidc_pkg.sv]
// Shared types, constants and saturating arithmetic for the PID step block.
// Used by pidc_cfg_regs and pid_step_with_clamps; depends on nothing else.
package pidc_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic signed [DATA_WIDTH-1:0]   word_t;
  typedef logic signed [2*DATA_WIDTH-1:0] prod_t;
  typedef logic signed [DATA_WIDTH:0]     wide_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Whole number in fixed point, saturated to WORD_MAX when it is too large
  function automatic word_t qconst(input int n);
    longint v;
    v = longint'(n) <<< FRAC_BITS;
    return (v > longint'(WORD_MAX)) ? WORD_MAX : word_t'(v);
  endfunction

  localparam word_t INT_LIMIT       = qconst(12);
  localparam word_t INT_LIMIT_NEG   = -INT_LIMIT;
  localparam word_t ERR_LIMIT       = qconst(30);
  localparam word_t ERR_LIMIT_NEG   = -ERR_LIMIT;
  localparam word_t DRIVE_LIMIT     = qconst(1);
  localparam word_t DRIVE_LIMIT_NEG = -DRIVE_LIMIT;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CONTROL_MODE  = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I        = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_TARGET        = 3'd4,
    REG_INTEGRAL_LOW  = 3'd5,
    REG_INTEGRAL_HIGH = 3'd6
  } reg_index_t;

  typedef struct packed {
    word_t sample;
    logic  clear_history;
  } req_t;

  typedef struct packed {
    word_t drive;
    word_t error_value;
  } rsp_t;

  typedef struct packed {
    logic  control_mode;
    word_t gain_p;
    word_t gain_i;
    word_t gain_d;
    word_t target;
    word_t integral_low;
    word_t integral_high;
  } cfg_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    wide_t s;
    s = wide_t'(a) - wide_t'(b);
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  // Raise to lo first, then lower to hi: hi wins when the limits cross
  function automatic word_t clamp(input word_t x, input word_t lo, input word_t hi);
    word_t y;
    y = (x < lo) ? lo : x;
    y = (y > hi) ? hi : y;
    return y;
  endfunction

  // Fixed-point product, floored by the arithmetic shift, then saturated
  function automatic word_t qmul(input word_t a, input word_t b);
    prod_t p;
    prod_t q;
    p = prod_t'(a) * prod_t'(b);
    q = p >>> FRAC_BITS;
    if (q > prod_t'(WORD_MAX)) begin
      return WORD_MAX;
    end
    if (q < prod_t'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return q[DATA_WIDTH-1:0];
  endfunction

endpackage

[rtl/core/pidc_cfg_regs.sv]
// Configuration register file of the PID step block.
// Depends on pidc_pkg for the register indexes and the cfg_t struct.
module pidc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pidc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pidc_pkg::DATA_WIDTH-1:0]      cfg_data,
  output pidc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pidc_pkg::REG_CONTROL_MODE:  cfg.control_mode  <= cfg_data[0];
        pidc_pkg::REG_GAIN_P:        cfg.gain_p        <= cfg_data;
        pidc_pkg::REG_GAIN_I:        cfg.gain_i        <= cfg_data;
        pidc_pkg::REG_GAIN_D:        cfg.gain_d        <= cfg_data;
        pidc_pkg::REG_TARGET:        cfg.target        <= cfg_data;
        pidc_pkg::REG_INTEGRAL_LOW:  cfg.integral_low  <= cfg_data;
        pidc_pkg::REG_INTEGRAL_HIGH: cfg.integral_high <= cfg_data;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

[rtl/core/pid_step_with_clamps.sv]
// PID step in signed fixed point: five-stage pipeline, one word per cycle unless stalled.
// A request word passes through registers A, B, C and D into the result register on rsp_valid.
// Throughput: one word per cycle unless stalled; the integral and last-error update
// in stage B is the loop that sets it. A clear word updates history and yields no result.
// Reset (synchronous): empties the pipeline, zeroes history and the configuration registers.
// Depends on pidc_pkg and pidc_cfg_regs.
module pid_step_with_clamps (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  pidc_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output pidc_pkg::rsp_t                      rsp,
  input  logic                                cfg_write,
  input  logic [pidc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pidc_pkg::DATA_WIDTH-1:0]      cfg_data
);

  pidc_pkg::cfg_t cfg;

  pidc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage registers
  logic                  a_valid, a_clear;
  pidc_pkg::word_t       a_err;
  logic                  b_valid, b_keep;
  pidc_pkg::word_t       b_err, b_diff, b_integ;
  logic                  c_valid;
  pidc_pkg::word_t       c_p, c_i, c_d, c_err;
  logic                  d_valid;
  pidc_pkg::word_t       d_sum, d_third, d_err;

  // History
  pidc_pkg::word_t       last_error, integral_sum;
  pidc_pkg::word_t       integral_sum_next, diff_next, integ_sum_raw;
  pidc_pkg::word_t       total, err_in;
  logic                  keep_next;

  logic e_ready, d_ready, c_ready, b_ready, a_ready;

  assign e_ready   = !rsp_valid || !rsp_stall;
  assign d_ready   = !d_valid || e_ready;
  assign c_ready   = !c_valid || d_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req_stall = !a_ready;

  // Stage A: form the error from the request word
  assign err_in = cfg.control_mode ? pidc_pkg::sat_sub(cfg.target, req.sample) : req.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req_valid;
      if (req_valid) begin
        a_clear <= req.clear_history;
        a_err   <= err_in;
      end
    end
  end

  // Stage B: history update
  always_comb begin
    integ_sum_raw = pidc_pkg::sat_add(integral_sum, a_err);
    diff_next     = pidc_pkg::sat_sub(a_err, last_error);
    if (cfg.control_mode) begin
      integral_sum_next = pidc_pkg::clamp(integ_sum_raw, pidc_pkg::INT_LIMIT_NEG,
                                          pidc_pkg::INT_LIMIT);
    end else begin
      integral_sum_next = pidc_pkg::clamp(integ_sum_raw, cfg.integral_low,
                                          cfg.integral_high);
    end
    keep_next = !(a_err > pidc_pkg::ERR_LIMIT || a_err < pidc_pkg::ERR_LIMIT_NEG);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      last_error   <= '0;
      integral_sum <= '0;
    end else if (b_ready) begin
      b_valid <= a_valid && !a_clear;
      if (a_valid) begin
        if (a_clear) begin
          last_error   <= '0;
          integral_sum <= '0;
        end else begin
          last_error   <= a_err;
          integral_sum <= integral_sum_next;
          b_err        <= a_err;
          b_diff       <= diff_next;
          b_integ      <= integral_sum_next;
          b_keep       <= keep_next;
        end
      end
    end
  end

  // Stage C: the three products
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
      if (b_valid) begin
        c_p   <= pidc_pkg::qmul(cfg.gain_p, b_err);
        c_d   <= pidc_pkg::qmul(cfg.gain_d, b_diff);
        c_i   <= (cfg.control_mode && !b_keep) ? '0 : pidc_pkg::qmul(cfg.gain_i, b_integ);
        c_err <= b_err;
      end
    end
  end

  // Stage D: first sum; the order of terms differs by mode
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
      if (c_valid) begin
        d_sum   <= pidc_pkg::sat_add(c_p, cfg.control_mode ? c_i : c_d);
        d_third <= cfg.control_mode ? c_d : c_i;
        d_err   <= c_err;
      end
    end
  end

  // Stage E: last sum, output clamp, result register
  assign total = pidc_pkg::sat_add(d_sum, d_third);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (e_ready) begin
      rsp_valid <= d_valid;
      if (d_valid) begin
        rsp.drive       <= cfg.control_mode ?
                           pidc_pkg::clamp(total, pidc_pkg::DRIVE_LIMIT_NEG,
                                           pidc_pkg::DRIVE_LIMIT) : total;
        rsp.error_value <= d_err;
      end
    end
  end

  a_clear_zeroes_history: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_ready && a_clear) |=> (last_error == '0 && integral_sum == '0))
    else $error("history not cleared after a clear word");

  a_mode1_integral_bounded: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_ready && !a_clear && cfg.control_mode) |=>
      (integral_sum >= pidc_pkg::INT_LIMIT_NEG && integral_sum <= pidc_pkg::INT_LIMIT))
    else $error("integral outside fixed clamp in measurement mode");

  a_mode1_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && cfg.control_mode) |->
      (rsp.drive >= pidc_pkg::DRIVE_LIMIT_NEG && rsp.drive <= pidc_pkg::DRIVE_LIMIT))
    else $error("drive outside +-1.0 in measurement mode");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !a_valid && !b_valid && !c_valid && !d_valid))
    else $error("pipeline not empty after reset");

endmodule

[tb/tb_pid_step_with_clamps.sv]
// Self-checking bench for pid_step_with_clamps: drives request words, predicts each
// response in both control modes and checks it field by field under random stalls.
// Depends on pidc_pkg and the RTL of the block under test.
module tb_pid_step_with_clamps;

  localparam int     SLACK_CYCLES = 8;
  localparam longint W_MAX        = 64'sd2147483647;
  localparam longint W_MIN        = -64'sd2147483648;
  localparam longint INT_CAP      = 64'sd12 <<< pidc_pkg::FRAC_BITS;
  localparam longint ERR_BIG      = 64'sd30 <<< pidc_pkg::FRAC_BITS;
  localparam longint DRIVE_CAP    = 64'sd1 <<< pidc_pkg::FRAC_BITS;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  pidc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  pidc_pkg::rsp_t rsp;
  logic cfg_write = 1'b0;
  logic [pidc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [pidc_pkg::DATA_WIDTH-1:0] cfg_data = '0;

  pid_step_with_clamps dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Controller copy: settings and history
  bit     mode_sel = 1'b0;
  longint k_p = 0, k_i = 0, k_d = 0, setpoint = 0, int_lo = 0, int_hi = 0;
  longint prev_err = 0, int_acc = 0;

  pidc_pkg::rsp_t pending_q[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_req = 0;
  int   mismatches = 0;
  int   words_sent = 0;
  int   clears_sent = 0;
  int   results_checked = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_pid_step_with_clamps: FAIL");
    $finish;
  end

  function automatic longint fit_word(input longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  // Exact product, floored by the arithmetic shift, then saturated
  function automatic longint fx_mul(input longint a, input longint b);
    longint prod;
    prod = a * b;
    return fit_word(prod >>> pidc_pkg::FRAC_BITS);
  endfunction

  function automatic longint bound(input longint x, input longint lo, input longint hi);
    longint y;
    y = (x < lo) ? lo : x;
    return (y > hi) ? hi : y;
  endfunction

  // Advance the controller copy by one word; returns 0 for a clear
  function automatic bit predict_word(input pidc_pkg::req_t w, output pidc_pkg::rsp_t r);
    longint s, e, drive, iterm, diff;
    s = longint'(w.sample);
    r = '0;
    if (w.clear_history) begin
      prev_err = 0;
      int_acc  = 0;
      return 1'b0;
    end
    if (!mode_sel) begin
      e        = s;
      diff     = fit_word(e - prev_err);
      prev_err = e;
      int_acc  = bound(fit_word(int_acc + e), int_lo, int_hi);
      drive    = fit_word(fit_word(fx_mul(k_p, e) + fx_mul(k_d, diff)) + fx_mul(int_acc, k_i));
    end else begin
      e        = fit_word(setpoint - s);
      int_acc  = bound(fit_word(int_acc + e), -INT_CAP, INT_CAP);
      diff     = fit_word(e - prev_err);
      prev_err = e;
      iterm    = (e > ERR_BIG || e < -ERR_BIG) ? 0 : fx_mul(k_i, int_acc);
      drive    = fit_word(fit_word(fx_mul(k_p, e) + iterm) + fx_mul(k_d, diff));
      drive    = bound(drive, -DRIVE_CAP, DRIVE_CAP);
    end
    r.drive       = pidc_pkg::word_t'(drive);
    r.error_value = pidc_pkg::word_t'(e);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input pidc_pkg::word_t got,
                                 input pidc_pkg::word_t want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        repeat (n) begin
          rsp_stall <= 1'b1;
          @(posedge clk);
        end
      end
      rsp_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pidc_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("word with nothing pending", rsp.drive, '0);
      end else begin
        want = pending_q.pop_front();
        results_checked++;
        if (rsp.drive !== want.drive) report_mismatch("drive", rsp.drive, want.drive);
        if (rsp.error_value !== want.error_value)
          report_mismatch("error_value", rsp.error_value, want.error_value);
      end
    end
  end

  task automatic send_word(input pidc_pkg::word_t sample, input bit clear);
    pidc_pkg::req_t w;
    pidc_pkg::rsp_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    w.sample        = sample;
    w.clear_history = clear;
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    words_sent++;
    if (predict_word(w, r)) pending_q.push_back(r);
    else clears_sent++;
  endtask

  // Hold the sender until every response is in, then let a clear flush through
  task automatic drain_results;
    req_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SLACK_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pidc_pkg::reg_index_t idx, input pidc_pkg::word_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      pidc_pkg::REG_CONTROL_MODE:  mode_sel = val[0];
      pidc_pkg::REG_GAIN_P:        k_p      = longint'(val);
      pidc_pkg::REG_GAIN_I:        k_i      = longint'(val);
      pidc_pkg::REG_GAIN_D:        k_d      = longint'(val);
      pidc_pkg::REG_TARGET:        setpoint = longint'(val);
      pidc_pkg::REG_INTEGRAL_LOW:  int_lo   = longint'(val);
      pidc_pkg::REG_INTEGRAL_HIGH: int_hi   = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input bit mode, input pidc_pkg::word_t p, input pidc_pkg::word_t i,
                            input pidc_pkg::word_t d, input pidc_pkg::word_t tgt,
                            input pidc_pkg::word_t lo, input pidc_pkg::word_t hi);
    write_reg(pidc_pkg::REG_CONTROL_MODE, pidc_pkg::word_t'(mode));
    write_reg(pidc_pkg::REG_GAIN_P, p);
    write_reg(pidc_pkg::REG_GAIN_I, i);
    write_reg(pidc_pkg::REG_GAIN_D, d);
    write_reg(pidc_pkg::REG_TARGET, tgt);
    write_reg(pidc_pkg::REG_INTEGRAL_LOW, lo);
    write_reg(pidc_pkg::REG_INTEGRAL_HIGH, hi);
    cfg_write <= 1'b0;
  endtask

  function automatic pidc_pkg::word_t pick_extreme();
    case ($urandom_range(3))
      0:       return pidc_pkg::WORD_MAX;
      1:       return pidc_pkg::WORD_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic pidc_pkg::word_t pick_gain();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return pick_extreme();
      default: return int'($urandom_range(0, 6 << pidc_pkg::FRAC_BITS))
                      - (3 << pidc_pkg::FRAC_BITS);
    endcase
  endfunction

  function automatic pidc_pkg::word_t pick_level();
    if ($urandom_range(5) == 0) return pick_extreme();
    return int'($urandom_range(0, 40 << pidc_pkg::FRAC_BITS)) - (20 << pidc_pkg::FRAC_BITS);
  endfunction

  // Errors mostly in +-40.0, some at the drop threshold, some full range or extreme
  function automatic pidc_pkg::word_t pick_sample();
    longint off;
    case ($urandom_range(9))
      0: return $urandom;
      1: return pick_extreme();
      2: off = ($urandom_range(1) ? ERR_BIG : -ERR_BIG) + $urandom_range(2) - 1;
      default: off = longint'($urandom_range(0, 80 << pidc_pkg::FRAC_BITS))
                     - (40 << pidc_pkg::FRAC_BITS);
    endcase
    return mode_sel ? pidc_pkg::word_t'(setpoint - off) : pidc_pkg::word_t'(off);
  endfunction

  task automatic test_defaults;
    send_word(pidc_pkg::WORD_MAX, 1'b0);
    send_word(pidc_pkg::WORD_MIN, 1'b0);
    drain_results();
  endtask

  task automatic test_mode0_directed;
    set_config(1'b0, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MIN, 1 << pidc_pkg::FRAC_BITS, '0,
               -(5 << pidc_pkg::FRAC_BITS), 5 << pidc_pkg::FRAC_BITS);
    send_word(pidc_pkg::WORD_MAX, 1'b0);
    send_word(pidc_pkg::WORD_MIN, 1'b0);
    send_word(pidc_pkg::WORD_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(1, 1'b0);
    send_word(pidc_pkg::WORD_MAX, 1'b1);
    send_word(32'h0001_8000, 1'b0);
    drain_results();
    // crossed limits: the upper one wins
    set_config(1'b0, 32'h0000_8000, 1 << pidc_pkg::FRAC_BITS, -(1 << pidc_pkg::FRAC_BITS), '0,
               3 << pidc_pkg::FRAC_BITS, -(3 << pidc_pkg::FRAC_BITS));
    send_word(2 << pidc_pkg::FRAC_BITS, 1'b0);
    send_word(-(7 << pidc_pkg::FRAC_BITS), 1'b0);
    send_word(1, 1'b0);
    drain_results();
  endtask

  task automatic test_mode1_directed;
    set_config(1'b1, 32'h0000_C000, 2 << pidc_pkg::FRAC_BITS, 32'h0000_4000,
               5 << pidc_pkg::FRAC_BITS, '0, '0);
    // errors on and just beyond the integral-drop threshold
    send_word(-(25 << pidc_pkg::FRAC_BITS), 1'b0);
    send_word(-(25 << pidc_pkg::FRAC_BITS) - 1, 1'b0);
    send_word(35 << pidc_pkg::FRAC_BITS, 1'b0);
    send_word((35 << pidc_pkg::FRAC_BITS) + 1, 1'b0);
    send_word(5 << pidc_pkg::FRAC_BITS, 1'b0);
    send_word('0, 1'b1);
    send_word(-(5 << pidc_pkg::FRAC_BITS), 1'b0);
    send_word(-(5 << pidc_pkg::FRAC_BITS), 1'b0);
    send_word(-(5 << pidc_pkg::FRAC_BITS), 1'b0);
    drain_results();
    set_config(1'b1, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MIN,
               pidc_pkg::WORD_MIN, pidc_pkg::WORD_MIN, pidc_pkg::WORD_MAX);
    send_word(pidc_pkg::WORD_MAX, 1'b0);
    send_word(pidc_pkg::WORD_MIN, 1'b0);
    drain_results();
  endtask

  task automatic test_random_phase(input int n_words);
    pidc_pkg::word_t a, b;
    a = pick_level();
    b = pick_level();
    if (($urandom_range(4) == 0) != (a > b)) begin
      set_config(1'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain(),
                 pick_level() <<< $urandom_range(2), b, a);
    end else begin
      set_config(1'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain(),
                 pick_level() <<< $urandom_range(2), a, b);
    end
    repeat (n_words) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
  endtask

  task automatic test_extreme_configs;
    set_config(1'b0, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MAX,
               pidc_pkg::WORD_MAX, pidc_pkg::WORD_MIN, pidc_pkg::WORD_MAX);
    repeat (25) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
    set_config(1'b0, pidc_pkg::WORD_MIN, pidc_pkg::WORD_MIN, pidc_pkg::WORD_MIN,
               pidc_pkg::WORD_MIN, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MIN);
    repeat (25) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
    set_config(1'b1, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MAX, pidc_pkg::WORD_MAX,
               pidc_pkg::WORD_MAX, '0, '0);
    repeat (25) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
    set_config(1'b1, pidc_pkg::WORD_MIN, pidc_pkg::WORD_MIN, pidc_pkg::WORD_MIN,
               pidc_pkg::WORD_MIN, '0, '0);
    repeat (25) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
  endtask

  // Long receiver hold-off so the pipeline fills and stalls the sender
  task automatic test_backpressure;
    set_config(1'b1, 32'h0000_4000, 32'h0000_2000, 32'h0000_1000, 2 << pidc_pkg::FRAC_BITS,
               '0, '0);
    hold_req = 80;
    repeat (40) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
    set_config(1'b0, pick_gain(), pick_gain(), pick_gain(), '0,
               -(8 << pidc_pkg::FRAC_BITS), 8 << pidc_pkg::FRAC_BITS);
    hold_req = 60;
    repeat (40) send_word(pick_sample(), $urandom_range(99) < 4);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_mode0_directed();
    test_mode1_directed();

    send_idle_pct = 15;
    recv_idle_pct = 85;
    repeat (4) test_random_phase(100);
    send_idle_pct = 85;
    recv_idle_pct = 15;
    repeat (4) test_random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) test_random_phase(100);
    test_extreme_configs();
    test_backpressure();

    $display("Sent %0d words (%0d history clears), checked %0d responses,", words_sent,
             clears_sent, results_checked);
    $display("both control modes, crossed and extreme limits, three stall patterns.");
    if (mismatches == 0) begin
      $display("tb_pid_step_with_clamps: PASS");
    end else begin
      $display("tb_pid_step_with_clamps: FAIL");
    end
    $finish;
  end

endmodule
